### src/assert_macros.svh
// Assertion helpers shared by the RTL. Both macros sample on the rising edge
// of clk and are disabled while rst_n is low; the names clk and rst_n must be
// visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### src/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Types and constants shared by the sorted list merge core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FIRST  = 2'd0,
        OP_PUSH_SECOND = 2'd1,
        OP_RUN         = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PICK,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last;
        logic                     empty_res;
    } res_t;

endpackage

`default_nettype wire

### src/sorted_list_merge_core.sv
// ----------------------------------------------------------------------------
// sorted_list_merge_core
// Two lists of signed words are filled by push commands; a run command merges
// them through one signed comparator into a single result stream.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake        | Payload
//  cmd     | in        | cmd_valid/ready  | cmd_t: op, value
//  res     | out       | res_valid/ready  | res_t: value_res, last, empty_res
//
// A push is accepted in the idle step. A run is accepted in the idle step and then
// each result takes a fetch step (memory read) and then a pick step (compare
// and load); a run of two empty lists goes to the empty step instead. The
// registered read of the list memories is why each result needs its fetch step.
// A pending result that is not taken stalls the sequencer in its pick or empty step.
// Reset clears the counts and control state; list memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_merge_core
    import slm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              first_wr_en;
    logic              second_wr_en;
    logic [ADDR_W-1:0] first_wr_addr;
    logic [ADDR_W-1:0] second_wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] first_rd_addr;
    logic [ADDR_W-1:0] second_rd_addr;
    logic [DATA_W-1:0] first_rd_data;
    logic [DATA_W-1:0] second_rd_data;

    slm_merge_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .first_wr_en    (first_wr_en),
        .second_wr_en   (second_wr_en),
        .first_wr_addr  (first_wr_addr),
        .second_wr_addr (second_wr_addr),
        .wr_data        (wr_data),
        .first_rd_addr  (first_rd_addr),
        .second_rd_addr (second_rd_addr),
        .first_rd_data  (first_rd_data),
        .second_rd_data (second_rd_data)
    );

    slm_list_mem #(
        .DEPTH (DEPTH)
    ) u_first_mem (
        .clk     (clk),
        .wr_en   (first_wr_en),
        .wr_addr (first_wr_addr),
        .wr_data (wr_data),
        .rd_addr (first_rd_addr),
        .rd_data (first_rd_data)
    );

    slm_list_mem #(
        .DEPTH (DEPTH)
    ) u_second_mem (
        .clk     (clk),
        .wr_en   (second_wr_en),
        .wr_addr (second_wr_addr),
        .wr_data (wr_data),
        .rd_addr (second_rd_addr),
        .rd_data (second_rd_data)
    );

endmodule

`default_nettype wire

### src/slm_list_mem.sv
// ----------------------------------------------------------------------------
// slm_list_mem
// Storage for one list: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slm_list_mem
    import slm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]                            wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [DATA_W-1:0]                            rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### src/slm_merge_ctrl.sv
// ----------------------------------------------------------------------------
// slm_merge_ctrl
// Command decode, list counters and the merge sequencer with its one shared
// signed comparator and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module slm_merge_ctrl
    import slm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         cmd_valid,
    output logic                                              cmd_ready,
    input  wire cmd_t                                         cmd,
    output logic                                              res_valid,
    input  wire logic                                         res_ready,
    output res_t                                              res,
    output logic                                              first_wr_en,
    output logic                                              second_wr_en,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      first_wr_addr,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      second_wr_addr,
    output logic [DATA_W-1:0]                                 wr_data,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      first_rd_addr,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      second_rd_addr,
    input  wire logic [DATA_W-1:0]                            first_rd_data,
    input  wire logic [DATA_W-1:0]                            second_rd_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0]  second_cnt_reg, second_cnt_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic              cmd_fire;
    logic              slot_free;
    logic              load;
    logic              take_first;
    logic              first_left;
    logic              second_left;
    logic              heads_le;
    logic [CNT_W-1:0]  i_inc;
    logic [CNT_W-1:0]  j_inc;
    logic              pick_last;
    res_t              pick_res;
    logic              cnt_in_range;
    logic              idx_in_range;
    logic              run_cleared;

    // ------------------------------------------------------------------
    // Shared compare unit and pick selection.
    // ------------------------------------------------------------------
    assign first_left  = (i_reg < first_cnt_reg);
    assign second_left = (j_reg < second_cnt_reg);
    assign heads_le    = ($signed(first_rd_data) <= $signed(second_rd_data));
    assign take_first  = first_left && (!second_left || heads_le);
    assign i_inc       = i_reg + CNT_W'(1);
    assign j_inc       = j_reg + CNT_W'(1);

    // The pick is the final one when both lists are used up after it.
    assign pick_last = take_first ? ((i_inc == first_cnt_reg) && (j_reg == second_cnt_reg))
                                  : ((i_reg == first_cnt_reg) && (j_inc == second_cnt_reg));

    assign slot_free = !res_valid_reg || res_ready;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // ------------------------------------------------------------------
    // Outputs of the sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_ready    = 1'b0;
        load         = 1'b0;
        first_wr_en  = 1'b0;
        second_wr_en = 1'b0;
        pick_res     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_PUSH_FIRST:  first_wr_en  = (first_cnt_reg < CNT_W'(DEPTH));
                        OP_PUSH_SECOND: second_wr_en = (second_cnt_reg < CNT_W'(DEPTH));
                        default:        ;
                    endcase
                end
            end
            ST_FETCH:
            begin
            end
            ST_PICK:
            begin
                load               = slot_free;
                pick_res.value_res = take_first ? first_rd_data : second_rd_data;
                pick_res.last      = pick_last;
                pick_res.empty_res = 1'b0;
            end
            ST_EMPTY:
            begin
                load               = slot_free;
                pick_res.value_res = '0;
                pick_res.last      = 1'b1;
                pick_res.empty_res = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_RUN))
                begin
                    if ((first_cnt_reg == '0) && (second_cnt_reg == '0))
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                if (load)
                begin
                    state_next = pick_last ? ST_IDLE : ST_FETCH;
                end
            end
            ST_EMPTY:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Counters, read indexes and the result register.
    // ------------------------------------------------------------------
    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !res_ready;

        if (first_wr_en)
        begin
            first_cnt_next = first_cnt_reg + CNT_W'(1);
        end
        if (second_wr_en)
        begin
            second_cnt_next = second_cnt_reg + CNT_W'(1);
        end
        if (cmd_fire && (cmd.op == OP_RUN))
        begin
            i_next = '0;
            j_next = '0;
        end
        if (load)
        begin
            res_next       = pick_res;
            res_valid_next = 1'b1;
            if (state_reg == ST_PICK)
            begin
                if (take_first)
                begin
                    i_next = i_inc;
                end
                else
                begin
                    j_next = j_inc;
                end
                if (pick_last)
                begin
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res            = res_reg;
    assign res_valid      = res_valid_reg;
    assign wr_data        = cmd.value;
    assign first_wr_addr  = first_cnt_reg[ADDR_W-1:0];
    assign second_wr_addr = second_cnt_reg[ADDR_W-1:0];
    assign first_rd_addr  = i_reg[ADDR_W-1:0];
    assign second_rd_addr = j_reg[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    assign cnt_in_range = (first_cnt_reg <= CNT_W'(DEPTH)) && (second_cnt_reg <= CNT_W'(DEPTH));
    assign idx_in_range = (state_reg == ST_IDLE) ||
                          ((i_reg <= first_cnt_reg) && (j_reg <= second_cnt_reg));
    assign run_cleared  = (state_reg == ST_IDLE) && (first_cnt_reg == '0) &&
                          (second_cnt_reg == '0);

    `ASSERT_ALWAYS(a_cnt_bound, cnt_in_range, "list count exceeds depth")
    `ASSERT_ALWAYS(a_idx_bound, idx_in_range, "merge index passed its list count")
    `ASSERT_NEXT(a_last_clears, load && pick_res.last, run_cleared, "run left open after last result")
    `ASSERT_NEXT(a_no_load_busy, load && !slot_free, 1'b0, "result overwritten while pending")

endmodule

`default_nettype wire
